// ===== rtl/lrc_tt_pkg.sv =====
// Package for the LRC time tag parser: result type, status codes and
// character and scaling constants. Depends on nothing.
`default_nettype none

package lrc_tt_pkg;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BAD   = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // Characters of the tag body
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_CLOSE = 8'h5D;

    // Counter limits and scaling
    localparam logic [16:0] MIN_MAX        = 17'd131071;
    localparam logic [6:0]  SEC_MAX        = 7'd127;
    localparam logic [6:0]  SEC_LIMIT      = 7'd60;
    localparam logic [1:0]  FRAC_DIGITS    = 2'd3;
    localparam logic [15:0] MS_PER_MIN     = 16'd60000;
    localparam logic [9:0]  MS_PER_SEC     = 10'd1000;

    typedef struct packed {
        logic        valid;
        logic [31:0] time_ms;
        logic [1:0]  status;
    } lrc_tt_result_t;

endpackage

`default_nettype wire

// ===== rtl/lrc_tt_if.sv =====
// Valid/ready channel interfaces of the LRC time tag parser: tag byte
// input and result output. Depends on nothing.
`default_nettype none

interface lrc_tt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] tag_byte;
    logic       tag_start;

    modport source (output valid, output tag_byte, output tag_start, input ready);
    modport sink   (input valid, input tag_byte, input tag_start, output ready);
endinterface

interface lrc_tt_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] time_ms;
    logic [1:0]  status;

    modport source (output valid, output time_ms, output status, input ready);
    modport sink   (input valid, input time_ms, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/lrc_tt_core.sv =====
// Tag parsing state machine and counters of the LRC time tag parser.
// Gives the result of the deciding byte in the same cycle. Uses lrc_tt_pkg.
`default_nettype none

module lrc_tt_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       accept,
    input  wire logic [7:0]                 tag_byte,
    input  wire logic                       tag_start,
    output lrc_tt_pkg::lrc_tt_result_t      res
);
    import lrc_tt_pkg::*;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_FIRST = 3'd1;
    localparam logic [2:0] PH_MIN   = 3'd2;
    localparam logic [2:0] PH_SEC   = 3'd3;
    localparam logic [2:0] PH_FRAC  = 3'd4;

    logic [2:0]  phase_reg, phase_next;
    logic [16:0] minute_count_reg, minute_count_next;
    logic [6:0]  second_count_reg, second_count_next;
    logic        second_seen_reg, second_seen_next;
    logic [9:0]  fraction_value_reg, fraction_value_next;
    logic [1:0]  fraction_count_reg, fraction_count_next;
    logic [32:0] minute_ms_reg, minute_ms_next;

    logic [2:0]  cur_phase;
    logic [6:0]  cur_sec;
    logic [9:0]  cur_frac;
    logic [1:0]  cur_fcount;
    logic        cur_seen;
    logic        is_digit;
    logic [3:0]  digit;
    logic [20:0] minute_sum;
    logic [10:0] second_sum;
    logic [9:0]  frac_ms;
    logic [16:0] sec_ms;
    logic [33:0] total_ms;
    logic        finish;

    always_comb
    begin
        is_digit   = (tag_byte >= CH_ZERO) && (tag_byte <= CH_NINE);
        digit      = is_digit ? tag_byte[3:0] : 4'd0;
        cur_phase  = tag_start ? PH_FIRST : phase_reg;
        cur_sec    = tag_start ? 7'd0 : second_count_reg;
        cur_frac   = tag_start ? 10'd0 : fraction_value_reg;
        cur_fcount = tag_start ? 2'd0 : fraction_count_reg;
        cur_seen   = tag_start ? 1'b0 : second_seen_reg;

        minute_sum = 21'(minute_count_reg) * 21'd10 + 21'(digit);
        second_sum = 11'(cur_sec) * 11'd10 + 11'(digit);

        // Scale the fraction to milliseconds; finish only sees the registered fraction
        unique case (fraction_count_reg)
            2'd1:    frac_ms = 10'(fraction_value_reg * 10'd100);
            2'd2:    frac_ms = 10'(fraction_value_reg * 10'd10);
            default: frac_ms = fraction_value_reg;
        endcase
        sec_ms   = 17'(second_count_reg) * 17'(MS_PER_SEC);
        total_ms = 34'(minute_ms_reg) + 34'(sec_ms) + 34'(frac_ms);

        phase_next          = phase_reg;
        minute_count_next   = tag_start ? 17'd0 : minute_count_reg;
        second_count_next   = cur_sec;
        second_seen_next    = cur_seen;
        fraction_value_next = cur_frac;
        fraction_count_next = cur_fcount;
        minute_ms_next      = minute_ms_reg;
        finish              = 1'b0;
        res.valid           = 1'b0;
        res.time_ms         = 32'd0;
        res.status          = ST_OK;

        if (tag_start)
        begin
            phase_next = PH_FIRST;
        end

        unique case (cur_phase)
            PH_FIRST:
            begin
                if (is_digit)
                begin
                    minute_count_next = 17'(digit);
                    phase_next        = PH_MIN;
                end
                else
                begin
                    res.valid  = 1'b1;
                    res.status = ST_BAD;
                end
            end
            PH_MIN:
            begin
                if (is_digit)
                begin
                    minute_count_next = (minute_sum > 21'(MIN_MAX)) ? MIN_MAX
                                                                    : minute_sum[16:0];
                end
                else if (tag_byte == CH_COLON)
                begin
                    phase_next     = PH_SEC;
                    minute_ms_next = 33'(minute_count_reg) * 33'(MS_PER_MIN);
                end
                else
                begin
                    res.valid  = 1'b1;
                    res.status = ST_BAD;
                end
            end
            PH_SEC:
            begin
                if (is_digit)
                begin
                    second_count_next = (second_sum > 11'(SEC_MAX)) ? SEC_MAX
                                                                    : second_sum[6:0];
                    second_seen_next  = 1'b1;
                end
                else if (!cur_seen)
                begin
                    res.valid  = 1'b1;
                    res.status = ST_BAD;
                end
                else if (cur_sec >= SEC_LIMIT)
                begin
                    res.valid  = 1'b1;
                    res.status = ST_RANGE;
                end
                else if (tag_byte == CH_DOT || tag_byte == CH_COLON)
                begin
                    phase_next = PH_FRAC;
                end
                else if (tag_byte == CH_CLOSE)
                begin
                    finish = 1'b1;
                end
                else
                begin
                    res.valid  = 1'b1;
                    res.status = ST_BAD;
                end
            end
            PH_FRAC:
            begin
                if (is_digit)
                begin
                    if (cur_fcount >= FRAC_DIGITS)
                    begin
                        res.valid  = 1'b1;
                        res.status = ST_BAD;
                    end
                    else
                    begin
                        fraction_value_next = cur_frac * 10'd10 + 10'(digit);
                        fraction_count_next = cur_fcount + 2'd1;
                    end
                end
                else if (cur_fcount == 2'd0 || tag_byte != CH_CLOSE)
                begin
                    res.valid  = 1'b1;
                    res.status = ST_BAD;
                end
                else
                begin
                    finish = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        if (finish)
        begin
            res.valid = 1'b1;
            if (total_ms[33:32] != 2'd0)
            begin
                res.status = ST_RANGE;
            end
            else
            begin
                res.time_ms = total_ms[31:0];
            end
        end

        // Drop back to idle once the tag is decided
        if (res.valid)
        begin
            phase_next = PH_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            minute_count_reg   <= minute_count_next;
            second_count_reg   <= second_count_next;
            second_seen_reg    <= second_seen_next;
            fraction_value_reg <= fraction_value_next;
            fraction_count_reg <= fraction_count_next;
            minute_ms_reg      <= minute_ms_next;
        end
    end

    a_err_zero_time: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.status != ST_OK |-> res.time_ms == 32'd0)
        else $error("nonzero time on failed tag");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.status == ST_OK || res.status == ST_BAD
                       || res.status == ST_RANGE))
        else $error("undefined status code");

    a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res.valid |=> phase_reg == PH_IDLE)
        else $error("parser not idle after decision");

endmodule

`default_nettype wire

// ===== rtl/lrc_time_tag_parser.sv =====
// LRC time tag parser, top level: byte channel in, result channel out.
// A result is offered in the cycle after its deciding byte is accepted.
// Throughput: one byte per cycle; the single output register keeps input open
// whenever that register is empty or is being drained in the same cycle.
// Reset (rst_n low, asynchronous) returns the parser to idle and empties the
// output register; counters need no reset since tag start clears them.
// Uses lrc_tt_pkg, lrc_tt_if and lrc_tt_core.
`default_nettype none

module lrc_time_tag_parser (
    input  wire logic     clk,
    input  wire logic     rst_n,
    lrc_tt_in_if.sink     tag,
    lrc_tt_out_if.source  result
);
    import lrc_tt_pkg::*;

    lrc_tt_result_t core_res;
    logic           in_beat;
    logic           load;
    logic           out_valid_reg, out_valid_next;
    logic [31:0]    time_ms_reg;
    logic [1:0]     status_reg;

    // Take a byte whenever the result register is free or draining now
    assign tag.ready = !out_valid_reg || result.ready;
    assign in_beat   = tag.valid && tag.ready;
    assign load      = in_beat && core_res.valid;

    lrc_tt_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_beat),
        .tag_byte  (tag.tag_byte),
        .tag_start (tag.tag_start),
        .res       (core_res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result payload until its beat is taken
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            time_ms_reg <= core_res.time_ms;
            status_reg  <= core_res.status;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.time_ms = time_ms_reg;
    assign result.status  = status_reg;

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result.ready |-> !tag.ready)
        else $error("input taken while result stalled");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && core_res.valid |=> out_valid_reg)
        else $error("decided tag lost");

    a_result_drained: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result.ready && !load |=> !out_valid_reg)
        else $error("result repeated after its beat");

endmodule

`default_nettype wire
